[rtl/b3sc_pkg.sv]
// ============================================================================
// b3sc_pkg
// Shared types, constants and functions for the single-chunk BLAKE3 hasher.
// ============================================================================
package b3sc_pkg;

    localparam int unsigned MAX_MESSAGE_BYTES_DEFAULT = 1024;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS = 7;

    localparam logic [31:0] FLAG_START = 32'h0000_0001;
    localparam logic [31:0] FLAG_END   = 32'h0000_0002;
    localparam logic [31:0] FLAG_ROOT  = 32'h0000_0008;

    localparam logic [31:0] IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [3:0] PERM [16] = '{
        4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
        4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
    };

    // State-word indexes a, b, c, d for each of the eight G calls of a round
    localparam logic [3:0] GA [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd3};
    localparam logic [3:0] GB [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4};
    localparam logic [3:0] GC [8] = '{4'd8, 4'd9, 4'd10, 4'd11, 4'd10, 4'd11, 4'd8, 4'd9};
    localparam logic [3:0] GD [8] = '{4'd12, 4'd13, 4'd14, 4'd15, 4'd15, 4'd12, 4'd13, 4'd14};

    // Controller to datapath commands
    typedef struct packed {
        logic absorb;     // write byte into buffer
        logic start;      // load state for a compression
        logic final_blk;  // compression is the last (root) block
        logic step;       // run one half-G step
        logic finish_cv;  // fold state into chaining value, clear buffer
        logic clear;      // return to reset state
    } b3sc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic comp_done;  // last half-G step issued
        logic buf_full;   // 64 bytes buffered
        logic len_full;   // message length at limit
    } b3sc_status_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/b3sc_datapath.sv]
// ============================================================================
// b3sc_datapath
// Block buffer, chaining value and a shared half-G unit for compression.
// ============================================================================
module b3sc_datapath #(
    parameter int unsigned MAX_MESSAGE_BYTES = b3sc_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b3sc_pkg::b3sc_cmd_t   cmd,
    input  logic [7:0]            byte_in,
    input  logic [2:0]            out_sel,
    output b3sc_pkg::b3sc_status_t status,
    output logic [31:0]           digest_word
);
    import b3sc_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);

    logic [31:0] cv_reg [8];
    logic [31:0] cv_next [8];
    // block buffer held as 16 little-endian message words
    logic [31:0] buf_reg [16];
    logic [6:0]  count_reg;
    logic        any_block_reg;
    logic [LEN_W-1:0] len_reg;
    logic [31:0] v_reg [16];
    logic [31:0] m_reg [16];
    // step counter: round (3b), G index (3b), half (1b)
    logic [2:0]  round_reg;
    logic [2:0]  g_reg;
    logic        half_reg;

    logic [31:0] msg [16];
    logic [31:0] a, b, c, d, mw, a1, d1, c1, b1;
    logic        last_step;

    // Message words from buffer
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            msg[i] = buf_reg[i];
        end
    end

    // Half of G: one add chain, xor-rotate, add, xor-rotate
    always_comb
    begin
        a  = v_reg[GA[g_reg]];
        b  = v_reg[GB[g_reg]];
        c  = v_reg[GC[g_reg]];
        d  = v_reg[GD[g_reg]];
        mw = m_reg[{g_reg, half_reg}];
        a1 = a + b + mw;
        d1 = half_reg ? rotr(d ^ a1, 8) : rotr(d ^ a1, 16);
        c1 = c + d1;
        b1 = half_reg ? rotr(b ^ c1, 7) : rotr(b ^ c1, 12);
    end

    assign last_step = (round_reg == 3'(ROUNDS - 1)) && (g_reg == 3'd7) && half_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cv_next[i] = v_reg[i] ^ v_reg[i+8];
        end
    end

    assign status.comp_done = cmd.step && last_step;
    assign status.buf_full  = (count_reg == 7'(BLOCK_BYTES));
    assign status.len_full  = (len_reg >= LEN_W'(MAX_MESSAGE_BYTES));
    // digest comes straight from the state of the root compression
    assign digest_word      = cv_next[out_sel];

    // Control-like state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            any_block_reg <= 1'b0;
            len_reg       <= '0;
            round_reg     <= '0;
            g_reg         <= '0;
            half_reg      <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= IV[i];
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg     <= '0;
                any_block_reg <= 1'b0;
                len_reg       <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    cv_reg[i] <= IV[i];
                end
            end
            else if (cmd.finish_cv)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    cv_reg[i] <= cv_next[i];
                end
                if (!cmd.final_blk)
                begin
                    count_reg     <= '0;
                    any_block_reg <= 1'b1;
                end
            end
            else if (cmd.absorb)
            begin
                count_reg <= count_reg + 7'd1;
                len_reg   <= len_reg + LEN_W'(1);
            end
            if (cmd.start)
            begin
                round_reg <= '0;
                g_reg     <= '0;
                half_reg  <= 1'b0;
            end
            else if (cmd.step)
            begin
                half_reg <= ~half_reg;
                if (half_reg)
                begin
                    g_reg <= g_reg + 3'd1;
                    if (g_reg == 3'd7)
                    begin
                        round_reg <= round_reg + 3'd1;
                    end
                end
            end
        end
    end

    // Buffer and compression state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                buf_reg[i] <= '0;
            end
        end
        else if (cmd.clear || (cmd.finish_cv && !cmd.final_blk))
        begin
            for (int i = 0; i < 16; i++)
            begin
                buf_reg[i] <= '0;
            end
        end
        else if (cmd.absorb)
        begin
            buf_reg[count_reg[5:2]][{count_reg[1:0], 3'b000} +: 8] <= byte_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= cv_reg[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                v_reg[8+i] <= IV[i];
            end
            v_reg[12] <= '0;
            v_reg[13] <= '0;
            v_reg[14] <= 32'(count_reg);
            v_reg[15] <= (cmd.final_blk ? (FLAG_END | FLAG_ROOT) : 32'd0)
                         | (any_block_reg ? 32'd0 : FLAG_START);
            for (int i = 0; i < 16; i++)
            begin
                m_reg[i] <= msg[i];
            end
        end
        else if (cmd.step)
        begin
            v_reg[GA[g_reg]] <= a1;
            v_reg[GB[g_reg]] <= b1;
            v_reg[GC[g_reg]] <= c1;
            v_reg[GD[g_reg]] <= d1;
            // permute message after the last G of a round
            if (half_reg && (g_reg == 3'd7))
            begin
                for (int i = 0; i < 16; i++)
                begin
                    m_reg[i] <= m_reg[PERM[i]];
                end
            end
        end
    end

endmodule

[rtl/b3sc_ctrl.sv]
// ============================================================================
// b3sc_ctrl
// Controller: input handshake, compression sequencing, digest output.
// ============================================================================
module b3sc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  has_byte,
    input  logic                  end_msg,
    input  b3sc_pkg::b3sc_status_t status,
    output b3sc_pkg::b3sc_cmd_t   cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            out_sel,
    output logic                  ovf
);
    import b3sc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_COMP   = 5'b00100,
        ST_ABSORB = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   final_reg, final_next;   // compression in progress is the root
    logic   ovf_reg, ovf_next;
    logic [2:0] sel_reg, sel_next;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_sel   = sel_reg;
    assign ovf       = ovf_reg;

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        final_next    = final_reg;
        ovf_next      = ovf_reg;
        sel_next      = sel_reg;
        cmd           = '0;
        cmd.final_blk = final_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_byte && status.len_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (has_byte && !status.len_full && status.buf_full)
                    begin
                        // full block must be compressed before this byte
                        final_next    = 1'b0;
                        state_next    = ST_START;
                    end
                    else
                    begin
                        cmd.absorb = has_byte && !status.len_full;
                        if (end_msg)
                        begin
                            final_next = 1'b1;
                            state_next = ST_START;
                        end
                    end
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                cmd.step = 1'b1;
                if (status.comp_done)
                begin
                    state_next = final_reg ? ST_OUT : ST_ABSORB;
                    sel_next   = '0;
                end
            end
            ST_ABSORB:
            begin
                // state fold happens here; byte is written next cycle
                cmd.finish_cv = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    sel_next = sel_reg + 3'd1;
                    if (sel_reg == 3'd7)
                    begin
                        cmd.clear  = 1'b1;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            final_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            sel_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            final_reg    <= final_next;
            ovf_reg      <= ovf_next;
            sel_reg      <= sel_next;
        end
    end

endmodule

[rtl/b3sc_fold.sv]
// ============================================================================
// b3sc_fold
// Finishing sequencer for an absorb that waited on a block compression:
// after the chaining value fold, writes the held byte and, when the item
// also ended the message, launches the root compression.
// ============================================================================
module b3sc_fold (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_accept,
    input  logic [7:0]          data_in,
    input  logic                fold_now,
    input  logic                pend_end,
    input  b3sc_pkg::b3sc_cmd_t ctrl_cmd,
    output b3sc_pkg::b3sc_cmd_t dp_cmd,
    output logic [7:0]          byte_out,
    output logic                busy,
    output logic                kick
);
    import b3sc_pkg::*;

    logic [7:0] byte_reg;
    logic       wr_reg;
    logic       end_reg;

    // Hold the accepted byte until it is written
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            end_reg <= 1'b0;
        end
        else
        begin
            wr_reg  <= fold_now;
            end_reg <= fold_now && pend_end;
        end
    end

    // Merge deferred write into the command stream
    always_comb
    begin
        dp_cmd = ctrl_cmd;
        if (wr_reg)
        begin
            dp_cmd.absorb = 1'b1;
        end
    end

    assign byte_out = wr_reg ? byte_reg : data_in;
    // deferred write cycle; input is held off
    assign busy     = wr_reg;
    // deferred write also closes the message
    assign kick     = wr_reg && end_reg;

endmodule

[rtl/blake3_single_chunk_hash.sv]
// ============================================================================
// blake3_single_chunk_hash
// Unkeyed BLAKE3-256 over one chunk, fed one message byte per item.
// ============================================================================
// Usage:
//   s_axis: one item per message byte; tdata = {end_of_message, has_byte,
//   data_byte}. has_byte=0 with end_of_message=1 closes an empty tail.
//   m_axis: eight items per message, tdata = digest word, tuser =
//   {status, last_word, word_index}.
// Timing: a byte that fits the block buffer is written as it is taken. The byte that
//   follows a full 64-byte block waits for one compression, run on a single
//   shared half-G unit: a load, the half-G steps of all 7 rounds, a fold and
//   the write of the held byte; input is held off until that write. End of
//   message starts the root compression (a load, then the half-G steps); the
//   first digest word is valid once its last step is done. Words follow one per
//   cycle while the receiver takes them.
// Stall: while digest words wait on m_axis_tready no input is taken; the
//   held word stays stable.
// Reset: chaining value returns to IV, buffer and counters clear. The chaining
//   value, buffer, byte counters and status are restored after the eighth digest word is taken.
// Bytes past MAX_MESSAGE_BYTES are dropped and status=1 is reported.
// ============================================================================
module blake3_single_chunk_hash #(
    parameter int unsigned MAX_MESSAGE_BYTES = b3sc_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [8] has_byte, [9] end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] digest_word
    output logic [4:0]  m_axis_tuser   // [2:0] word_index, [3] last_word, [4] status
);
    import b3sc_pkg::*;

    b3sc_cmd_t    ctrl_cmd, dp_cmd, kick_cmd;
    b3sc_status_t status;
    logic [7:0]   byte_w;
    logic [2:0]   sel;
    logic         ovf;
    logic         ready_c;
    logic         busy;
    logic         kick;
    logic         fold_now;
    logic         pend_end;
    logic         in_valid_c;
    logic         end_c;
    logic         u_pend_q;

    // A deferred end launches the root compression as a synthetic item
    assign in_valid_c    = busy ? kick : s_axis_tvalid;
    assign end_c         = busy ? 1'b1 : s_axis_tdata[9];
    assign s_axis_tready = ready_c && !busy;
    assign fold_now      = ctrl_cmd.finish_cv;

    b3sc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_c),
        .in_ready (ready_c),
        .has_byte (busy ? 1'b0 : s_axis_tdata[8]),
        .end_msg  (end_c),
        .status   (status),
        .cmd      (ctrl_cmd),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_sel  (sel),
        .ovf      (ovf)
    );

    assign pend_end = u_pend_q;
    // remember end flag of the last accepted item, used when it triggered an intermediate compress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_pend_q <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            u_pend_q <= s_axis_tdata[9];
        end
    end

    b3sc_fold u_fold (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_accept(s_axis_tvalid && s_axis_tready),
        .data_in  (s_axis_tdata[7:0]),
        .fold_now (fold_now),
        .pend_end (pend_end),
        .ctrl_cmd (ctrl_cmd),
        .dp_cmd   (kick_cmd),
        .byte_out (byte_w),
        .busy     (busy),
        .kick     (kick)
    );

    assign dp_cmd = kick_cmd;

    b3sc_datapath #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .byte_in    (byte_w),
        .out_sel    (sel),
        .status     (status),
        .digest_word(m_axis_tdata)
    );

    assign m_axis_tuser = {ovf, (sel == 3'd7), sel};

endmodule

[verif/tb.sv]
// ============================================================================
// tb
// Checks blake3_single_chunk_hash against a behavioral BLAKE3 single-chunk
// predictor: directed messages (empty, block edges, overflow), then random
// messages with bursty input and a stalling digest receiver.
// ============================================================================
module tb;

    import b3sc_pkg::*;

    localparam int unsigned MAX_BYTES  = 1024;
    localparam int unsigned IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        status;
    } digest_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] data_byte, [8] has_byte, [9] end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [4:0]  m_axis_tuser;   // [2:0] word_index, [3] last_word, [4] status

    // predictor state
    logic [31:0] hash_cv [8];
    logic [7:0]  hash_block [64];
    int unsigned hash_fill;
    int unsigned hash_blocks;
    int unsigned hash_len;
    logic        hash_ovf;

    digest_item_t digest_q [$];
    int unsigned  mismatches;
    int unsigned  idle_cycles;
    bit           rx_stall_mode;

    blake3_single_chunk_hash i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // BLAKE3 compression; returns the 16-word state after 7 rounds
    task automatic run_compress(input logic [31:0] blen, input logic [31:0] flags,
                                output logic [31:0] v [16]);
        logic [31:0] m [16];
        logic [31:0] t [16];
        int a, b, c, d;
        for (int i = 0; i < 16; i++)
        begin
            m[i] = {hash_block[4*i+3], hash_block[4*i+2], hash_block[4*i+1], hash_block[4*i]};
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_cv[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            v[8+i] = IV[i];
        end
        v[12] = 0;
        v[13] = 0;
        v[14] = blen;
        v[15] = flags;
        for (int r = 0; r < 7; r++)
        begin
            for (int g = 0; g < 8; g++)
            begin
                a = GA[g]; b = GB[g]; c = GC[g]; d = GD[g];
                v[a] = v[a] + v[b] + m[2*g];
                v[d] = ror32(v[d] ^ v[a], 16);
                v[c] = v[c] + v[d];
                v[b] = ror32(v[b] ^ v[c], 12);
                v[a] = v[a] + v[b] + m[2*g+1];
                v[d] = ror32(v[d] ^ v[a], 8);
                v[c] = v[c] + v[d];
                v[b] = ror32(v[b] ^ v[c], 7);
            end
            for (int i = 0; i < 16; i++)
            begin
                t[i] = m[PERM[i]];
            end
            m = t;
        end
    endtask

    function automatic void hash_clear();
        for (int i = 0; i < 8; i++)
        begin
            hash_cv[i] = IV[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            hash_block[i] = '0;
        end
        hash_fill   = 0;
        hash_blocks = 0;
        hash_len    = 0;
        hash_ovf    = 1'b0;
    endfunction

    // advance predictor by one accepted item, queueing any digest words
    task automatic predict_item(input logic [7:0] data, input logic has, input logic eom);
        logic [31:0] v [16];
        digest_item_t d;
        if (has)
        begin
            if (hash_len >= MAX_BYTES)
            begin
                hash_ovf = 1'b1;
            end
            else
            begin
                if (hash_fill >= 64)
                begin
                    run_compress(64, (hash_blocks == 0) ? FLAG_START : '0, v);
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_cv[i] = v[i] ^ v[i+8];
                    end
                    hash_blocks++;
                    for (int i = 0; i < 64; i++)
                    begin
                        hash_block[i] = '0;
                    end
                    hash_fill = 0;
                end
                hash_block[hash_fill] = data;
                hash_fill++;
                hash_len++;
            end
        end
        if (eom)
        begin
            run_compress(hash_fill, FLAG_END | FLAG_ROOT |
                         ((hash_blocks == 0) ? FLAG_START : '0), v);
            for (int i = 0; i < 8; i++)
            begin
                d.word   = v[i] ^ v[i+8];
                d.index  = i[2:0];
                d.last   = (i == 7);
                d.status = hash_ovf;
                digest_q.push_back(d);
            end
            hash_clear();
        end
    endtask

    // drive one item and wait for it to be taken; valid stays up for the next item
    task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
        s_axis_tdata  <= {6'b0, eom, has, data};
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_item(data, has, eom);
        @(negedge clk);
    endtask

    // random gap between bursts
    task automatic send_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
        end
        repeat (n) @(negedge clk);
    endtask

    task automatic send_message(input int unsigned nbytes, input bit with_tail,
                                input bit bursty);
        for (int unsigned i = 0; i < nbytes; i++)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b1,
                      !with_tail && (i == nbytes - 1));
            if (bursty)
            begin
                send_gap();
            end
        end
        if (with_tail || nbytes == 0)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
    endtask

    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_null_items();
        // no byte, no end: ignored
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_block_edges();
        send_message(64, 0, 0);
        send_message(65, 0, 0);
    endtask

    task automatic test_full_and_overflow();
        // 1024 bytes taken, the extra one dropped, full last block
        send_message(MAX_BYTES + 1, 1, 0);
    endtask

    task automatic test_random_messages();
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < 150)
        begin
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(0, 3);
                1:       n = 64 * $urandom_range(1, 2);
                2:       n = 0;
                default: n = $urandom_range(1, 70);
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_message(n, 1'($urandom_range(0, 1)), 1);
            sent += n + 1;
            if ($urandom_range(0, 7) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    // receiver stall pattern: alternates between always-ready and random stalls
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
        begin
            rx_stall_mode <= ~rx_stall_mode;
        end
        m_axis_tready <= rx_stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    // digest checker
    always @(posedge clk)
    begin
        digest_item_t exp_d;
        digest_item_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata, m_axis_tuser[2:0], m_axis_tuser[3], m_axis_tuser[4]};
            if (digest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected digest word %h tuser %h", m_axis_tdata, m_axis_tuser);
                end
            end
            else
            begin
                exp_d = digest_q.pop_front();
                if (got !== exp_d)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("digest mismatch: exp word %h idx %0d last %b st %b",
                                 exp_d.word, exp_d.index, exp_d.last, exp_d.status);
                        $display("                 got word %h idx %0d last %b st %b",
                                 got.word, got.index, got.last, got.status);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted item and no digest word taken
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        rx_stall_mode = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        hash_clear();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_message();
        test_null_items();
        test_block_edges();
        wait_drained();
        test_full_and_overflow();
        test_random_messages();
        wait_drained();

        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
